/* design/sphpen_pkg.sv */
// ----------------------------------------------------------------------------
// sphpen_pkg
// Shared widths and constants for the sphere pair penetration pipeline.
// ----------------------------------------------------------------------------
package sphpen_pkg;

  localparam int COORD_W  = 32;              // Q16.16 centre coordinate
  localparam int RADIUS_W = 30;              // Q14.16 radius
  localparam int DEPTH_W  = 31;              // radius sum / depth
  localparam int NORM_W   = 16;              // normal component port width
  localparam int MAG_W    = 31;              // axis distance once not far
  localparam int DIST2_W  = 62;              // squared distance while overlapping
  localparam int SQRT_STEPS = DIST2_W / 2;   // one root bit per stage
  localparam logic [DEPTH_W-1:0] NEAR_LIMIT = DEPTH_W'(66);  // 0.001 in Q16.16

  localparam int AXES = 3;

endpackage

/* design/sphere_pair_penetration.sv */
// ----------------------------------------------------------------------------
// sphere_pair_penetration
// Fully pipelined sphere versus sphere overlap test with depth and normal.
// ----------------------------------------------------------------------------
// One pair enters and one result leaves per clock while out_stall does not
// hold the output beat. The pipe has five front stages (difference,
// magnitude, squares, sum, compare), a 31 stage restoring square root with one
// root bit per stage, one stage that loads the divider from the root,
// NORMAL_FRAC_BITS + 1 restoring divide stages that run the three normal lanes
// side by side, and the output register. All stages share
// one advance enable: the pipe moves whenever the output register is empty or
// its beat is taken, so in_stall follows out_valid && out_stall. Pairs that
// do not overlap still flow through the root and divide stages; their fields
// are forced to zero at the output. Centres at most 0.001 apart give the normal
// (0, 1.0, 0). Normal components are Q1.NORMAL_FRAC_BITS, truncated toward
// zero and clamped to +/-1.0, then cut to the 16 bit ports.
// ----------------------------------------------------------------------------
module sphere_pair_penetration #(
  parameter int NORMAL_FRAC_BITS = 14
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [sphpen_pkg::COORD_W-1:0] a_x,
  input  logic signed [sphpen_pkg::COORD_W-1:0] a_y,
  input  logic signed [sphpen_pkg::COORD_W-1:0] a_z,
  input  logic        [sphpen_pkg::RADIUS_W-1:0] a_radius,
  input  logic signed [sphpen_pkg::COORD_W-1:0] b_x,
  input  logic signed [sphpen_pkg::COORD_W-1:0] b_y,
  input  logic signed [sphpen_pkg::COORD_W-1:0] b_z,
  input  logic        [sphpen_pkg::RADIUS_W-1:0] b_radius,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic        [sphpen_pkg::DEPTH_W-1:0] depth,
  output logic                                  overlapping,
  output logic signed [sphpen_pkg::NORM_W-1:0]  normal_x,
  output logic signed [sphpen_pkg::NORM_W-1:0]  normal_y,
  output logic signed [sphpen_pkg::NORM_W-1:0]  normal_z
);
  import sphpen_pkg::*;

  localparam int QW  = NORMAL_FRAC_BITS + 1;   // quotient bits, 0..2^N
  localparam int DVN = NORMAL_FRAC_BITS + 1;   // divide stages
  localparam int NW  = NORMAL_FRAC_BITS + 2;   // signed normal before cut
  localparam logic [QW-1:0] ONE_Q = QW'(1) << NORMAL_FRAC_BITS;

  // Global advance: move every stage when the output slot frees up.
  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // Stage 1: centre differences and radius sum.
  logic                    s1_vld;
  logic signed [COORD_W:0] s1_d [AXES];
  logic [DEPTH_W-1:0]      s1_rs;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else if (adv) begin
      s1_vld <= in_valid;
    end
    if (adv) begin
      s1_d[0] <= (COORD_W+1)'(b_x) - (COORD_W+1)'(a_x);
      s1_d[1] <= (COORD_W+1)'(b_y) - (COORD_W+1)'(a_y);
      s1_d[2] <= (COORD_W+1)'(b_z) - (COORD_W+1)'(a_z);
      s1_rs   <= DEPTH_W'(a_radius) + DEPTH_W'(b_radius);
    end
  end

  // Stage 2: magnitudes, signs, far-apart flag.
  logic                 s2_vld;
  logic [COORD_W-1:0]   s2_mag [AXES];
  logic [AXES-1:0]      s2_neg;
  logic                 s2_far;
  logic [DEPTH_W-1:0]   s2_rs;
  logic [COORD_W-1:0]   s1_mag [AXES];
  logic [AXES-1:0]      s1_far;

  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      s1_mag[i] = s1_d[i][COORD_W] ? COORD_W'(-s1_d[i]) : s1_d[i][COORD_W-1:0];
      s1_far[i] = s1_mag[i][COORD_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else if (adv) begin
      s2_vld <= s1_vld;
    end
    if (adv) begin
      for (int i = 0; i < AXES; i++) begin
        s2_mag[i] <= s1_mag[i];
        s2_neg[i] <= s1_d[i][COORD_W];
      end
      s2_far <= |s1_far;
      s2_rs  <= s1_rs;
    end
  end

  // Stage 3: squares.
  logic                 s3_vld;
  logic [DIST2_W-1:0]   s3_sq [AXES];
  logic [DIST2_W-1:0]   s3_rs2;
  logic [MAG_W-1:0]     s3_mag [AXES];
  logic [AXES-1:0]      s3_neg;
  logic                 s3_far;
  logic [DEPTH_W-1:0]   s3_rs;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_vld <= 1'b0;
    end else if (adv) begin
      s3_vld <= s2_vld;
    end
    if (adv) begin
      for (int i = 0; i < AXES; i++) begin
        s3_sq[i]  <= DIST2_W'(s2_mag[i][MAG_W-1:0]) * DIST2_W'(s2_mag[i][MAG_W-1:0]);
        s3_mag[i] <= s2_mag[i][MAG_W-1:0];
      end
      s3_rs2 <= DIST2_W'(s2_rs) * DIST2_W'(s2_rs);
      s3_neg <= s2_neg;
      s3_far <= s2_far;
      s3_rs  <= s2_rs;
    end
  end

  // Stage 4: squared distance.
  logic                 s4_vld;
  logic [DIST2_W+1:0]   s4_dist2;
  logic [DIST2_W-1:0]   s4_rs2;
  logic [MAG_W-1:0]     s4_mag [AXES];
  logic [AXES-1:0]      s4_neg;
  logic                 s4_far;
  logic [DEPTH_W-1:0]   s4_rs;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_vld <= 1'b0;
    end else if (adv) begin
      s4_vld <= s3_vld;
    end
    if (adv) begin
      s4_dist2 <= (DIST2_W+2)'(s3_sq[0]) + (DIST2_W+2)'(s3_sq[1])
                + (DIST2_W+2)'(s3_sq[2]);
      s4_rs2   <= s3_rs2;
      s4_mag   <= s3_mag;
      s4_neg   <= s3_neg;
      s4_far   <= s3_far;
      s4_rs    <= s3_rs;
    end
  end

  // Stage 5 feeds the root pipe: index 0 of the root arrays.
  logic                 sq_vld [SQRT_STEPS+1];
  logic [DIST2_W-1:0]   sq_v   [SQRT_STEPS+1];
  logic [DIST2_W:0]     sq_r   [SQRT_STEPS+1];
  logic [MAG_W-1:0]     sq_mag [SQRT_STEPS+1][AXES];
  logic [AXES-1:0]      sq_neg [SQRT_STEPS+1];
  logic                 sq_ovl [SQRT_STEPS+1];
  logic [DEPTH_W-1:0]   sq_rs  [SQRT_STEPS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_vld[0] <= 1'b0;
    end else if (adv) begin
      sq_vld[0] <= s4_vld;
    end
    if (adv) begin
      sq_v[0]   <= s4_dist2[DIST2_W-1:0];
      sq_r[0]   <= '0;
      sq_mag[0] <= s4_mag;
      sq_neg[0] <= s4_neg;
      sq_ovl[0] <= !s4_far && (s4_dist2 < (DIST2_W+2)'(s4_rs2));
      sq_rs[0]  <= s4_rs;
    end
  end

  // Restoring square root, one result bit per stage.
  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    localparam logic [DIST2_W:0] BIT = (DIST2_W+1)'(1) << (2 * (SQRT_STEPS - 1 - k));
    logic [DIST2_W:0] trial;
    logic             take;

    assign trial = sq_r[k] + BIT;
    assign take  = {1'b0, sq_v[k]} >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        sq_vld[k+1] <= 1'b0;
      end else if (adv) begin
        sq_vld[k+1] <= sq_vld[k];
      end
      if (adv) begin
        sq_v[k+1]   <= take ? sq_v[k] - trial[DIST2_W-1:0] : sq_v[k];
        sq_r[k+1]   <= take ? (sq_r[k] >> 1) + BIT : sq_r[k] >> 1;
        sq_mag[k+1] <= sq_mag[k];
        sq_neg[k+1] <= sq_neg[k];
        sq_ovl[k+1] <= sq_ovl[k];
        sq_rs[k+1]  <= sq_rs[k];
      end
    end
  end

  // Divide pipe: index 0 is loaded from the root result.
  logic                 dv_vld  [DVN+1];
  logic [MAG_W:0]       dv_rem  [DVN+1][AXES];
  logic [QW-1:0]        dv_q    [DVN+1][AXES];
  logic [MAG_W-1:0]     dv_dist [DVN+1];
  logic [AXES-1:0]      dv_neg  [DVN+1];
  logic                 dv_ovl  [DVN+1];
  logic                 dv_near [DVN+1];
  logic [DEPTH_W-1:0]   dv_rs   [DVN+1];
  logic [MAG_W-1:0]     root;

  assign root = sq_r[SQRT_STEPS][MAG_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_vld[0] <= 1'b0;
    end else if (adv) begin
      dv_vld[0] <= sq_vld[SQRT_STEPS];
    end
    if (adv) begin
      for (int i = 0; i < AXES; i++) begin
        dv_rem[0][i] <= {1'b0, sq_mag[SQRT_STEPS][i]};
        dv_q[0][i]   <= '0;
      end
      dv_dist[0] <= root;
      dv_neg[0]  <= sq_neg[SQRT_STEPS];
      dv_ovl[0]  <= sq_ovl[SQRT_STEPS];
      dv_near[0] <= root <= NEAR_LIMIT;
      dv_rs[0]   <= sq_rs[SQRT_STEPS];
    end
  end

  // Restoring divide: one quotient bit per stage, three lanes side by side.
  for (genvar j = 0; j < DVN; j++) begin : g_div
    logic [AXES-1:0]  take;
    logic [MAG_W:0]   left [AXES];

    always_comb begin
      for (int i = 0; i < AXES; i++) begin
        take[i] = dv_rem[j][i] >= {1'b0, dv_dist[j]};
        left[i] = take[i] ? dv_rem[j][i] - {1'b0, dv_dist[j]} : dv_rem[j][i];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_vld[j+1] <= 1'b0;
      end else if (adv) begin
        dv_vld[j+1] <= dv_vld[j];
      end
      if (adv) begin
        for (int i = 0; i < AXES; i++) begin
          // Remainder stays below the divisor, so the shift fits.
          dv_rem[j+1][i] <= {left[i][MAG_W-1:0], 1'b0};
          dv_q[j+1][i]   <= {dv_q[j][i][QW-2:0], take[i]};
        end
        dv_dist[j+1] <= dv_dist[j];
        dv_neg[j+1]  <= dv_neg[j];
        dv_ovl[j+1]  <= dv_ovl[j];
        dv_near[j+1] <= dv_near[j];
        dv_rs[j+1]   <= dv_rs[j];
      end
    end
  end

  // Output: clamp, apply sign, zero when apart, (0, 1.0, 0) when near.
  logic [QW-1:0]        qc   [AXES];
  logic signed [NW-1:0] nrm  [AXES];
  logic [NORM_W-1:0]    nout [AXES];

  always_comb begin
    for (int i = 0; i < AXES; i++) begin
      qc[i]  = (dv_q[DVN][i] > ONE_Q) ? ONE_Q : dv_q[DVN][i];
      nrm[i] = dv_neg[DVN][i] ? -$signed({1'b0, qc[i]}) : $signed({1'b0, qc[i]});
      nout[i] = NORM_W'(nrm[i]);
      if (!dv_ovl[DVN]) begin
        nout[i] = '0;
      end else if (dv_near[DVN]) begin
        nout[i] = (i == 1) ? NORM_W'({1'b0, ONE_Q}) : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= dv_vld[DVN];
    end
    if (adv) begin
      depth       <= dv_ovl[DVN] ? dv_rs[DVN] - DEPTH_W'(dv_dist[DVN]) : '0;
      overlapping <= dv_ovl[DVN];
      normal_x    <= nout[0];
      normal_y    <= nout[1];
      normal_z    <= nout[2];
    end
  end

  // Apart pairs leave with every field zero.
  a_apart_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !overlapping) |->
      (depth == '0 && normal_x == '0 && normal_y == '0 && normal_z == '0))
    else $error("non-overlapping beat carries nonzero fields");

  // Reset empties the output slot.
  a_rst_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // Output slot only changes when the pipe advances.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    $past(in_stall) && !$past(rst) |-> $stable(out_valid) && $stable(depth))
    else $error("output moved while pipe held");

  // Intake stalls exactly when the output beat waits.
  a_stall: assert property (@(posedge clk)
    in_stall == (out_valid && out_stall))
    else $error("intake stall mismatch");

endmodule
